// ----- hw/rtl/chained_hash_table_assert.svh -----
// Assertion macros shared by the checker of the chained hash table.
// Depends on nothing; included by the checker file.
`ifndef CHAINED_HASH_TABLE_ASSERT_SVH
`define CHAINED_HASH_TABLE_ASSERT_SVH
// Implication checked on every clock edge outside reset.
`define CHT_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");
// Implication whose consequent is checked in the following cycle.
`define CHT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");
`endif

// ----- hw/rtl/cht_pkg.sv -----
// Shared types and codes for the chained hash table.
// Depends on nothing; used by the controller, datapath and top level.
package cht_pkg;

  localparam logic [1:0] CmdInsert = 2'd0;
  localparam logic [1:0] CmdSearch = 2'd1;
  localparam logic [1:0] CmdDelete = 2'd2;

  localparam logic [1:0] StatDone     = 2'd0;
  localparam logic [1:0] StatNotFound = 2'd1;
  localparam logic [1:0] StatFull     = 2'd2;

  localparam int unsigned KeyW = 31;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // Capture the input beat and reduce the key.
    logic mod_step;   // One remainder step.
    logic rd_bucket;  // Read the bucket head and count.
    logic rd_node;    // Issue a node read at the walk pointer.
    logic advance;    // Take the node read data and move along the chain.
    logic do_insert;  // Perform the insert writes.
    logic do_delete;  // Perform the delete writes.
    logic finish;     // Form the result with the given status.
    logic [1:0] status;
  } cht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mod_done;
    logic free_empty;
    logic head_nil;
    logic walk_nil;
    logic key_match;
    logic next_nil;
    logic walk_limit;
  } cht_stat_t;

endpackage

// ----- hw/rtl/cht_ctrl.sv -----
// Controller state machine for the chained hash table.
// Depends on cht_pkg; drives the datapath through cht_cmd_t.
module cht_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        cmd_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  cht_pkg::cht_stat_t stat_i,
  output cht_pkg::cht_cmd_t  dp_cmd_o
);
  import cht_pkg::*;

  typedef enum logic [2:0] {
    StIdle, StMod, StHead, StRead, StCheck, StOut
  } state_e;

  state_e state_q;
  logic [1:0] op_q;

  assign in_ready_o  = (state_q == StIdle) || (state_q == StOut && out_ready_i);
  assign out_valid_o = (state_q == StOut);

  always_comb begin
    dp_cmd_o = '0;
    dp_cmd_o.status = StatNotFound;
    unique case (state_q)
      StIdle, StOut: dp_cmd_o.load = in_valid_i && in_ready_o;
      StMod: dp_cmd_o.mod_step = !stat_i.mod_done;
      StHead: begin
        dp_cmd_o.rd_bucket = 1'b1;
      end
      StRead: dp_cmd_o.rd_node = 1'b1;
      StCheck: begin
        if (op_q == CmdInsert) begin
          if (stat_i.walk_nil || stat_i.next_nil || stat_i.walk_limit) begin
            dp_cmd_o.do_insert = 1'b1;
            dp_cmd_o.finish = 1'b1;
            dp_cmd_o.status = StatDone;
          end else begin
            dp_cmd_o.advance = 1'b1;
          end
        end else if (stat_i.walk_nil || stat_i.walk_limit) begin
          dp_cmd_o.finish = 1'b1;
        end else if (stat_i.key_match) begin
          dp_cmd_o.do_delete = (op_q == CmdDelete);
          dp_cmd_o.finish = 1'b1;
          dp_cmd_o.status = StatDone;
        end else begin
          dp_cmd_o.advance = 1'b1;
        end
      end
      default: ;
    endcase
    if (state_q == StHead && op_q == CmdInsert && stat_i.free_empty) begin
      dp_cmd_o.finish = 1'b1;
      dp_cmd_o.status = StatFull;
    end
    if (state_q == StHead && op_q != CmdInsert && op_q != CmdSearch &&
        op_q != CmdDelete) begin
      dp_cmd_o.finish = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      op_q    <= CmdInsert;
    end else begin
      unique case (state_q)
        StIdle, StOut: begin
          if (in_valid_i && in_ready_o) begin
            state_q <= StMod;
            op_q    <= cmd_i;
          end else if (state_q == StOut && out_ready_i) begin
            state_q <= StIdle;
          end
        end
        StMod: if (stat_i.mod_done) state_q <= StHead;
        StHead: begin
          if (dp_cmd_o.finish) state_q <= StOut;
          else if (op_q == CmdInsert && stat_i.head_nil) state_q <= StCheck;
          else state_q <= StRead;
        end
        StRead: state_q <= StCheck;
        StCheck: state_q <= dp_cmd_o.finish ? StOut : StRead;
        default: state_q <= StIdle;
      endcase
    end
  end
endmodule

// ----- hw/rtl/cht_dp.sv -----
// Datapath of the chained hash table: bucket tables, node memories and walk.
// Depends on cht_pkg; commanded by cht_ctrl.
module cht_dp #(
  parameter int unsigned NUM_BUCKETS = 10,
  parameter int unsigned POOL_DEPTH  = 256
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [cht_pkg::KeyW-1:0] key_i,
  input  cht_pkg::cht_cmd_t  dp_cmd_i,
  output cht_pkg::cht_stat_t stat_o,
  output logic [1:0]        status_o,
  output logic [3:0]        bucket_o,
  output logic [8:0]        position_o,
  output logic [8:0]        chain_length_o
);
  import cht_pkg::*;

  localparam int unsigned BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam int unsigned NW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned IW = $clog2(POOL_DEPTH);
  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);
  localparam logic [NW-1:0] Nil = NW'(POOL_DEPTH);
  localparam logic [KeyW:0] NbExt = (KeyW + 1)'(NUM_BUCKETS);
  localparam logic [31:0] Recip = 32'(64'h1_0000_0000 / 64'(NUM_BUCKETS));

  // Node memories; the link memory is cleared by a fill-count scheme:
  // nodes at or beyond fill_q link to their successor.
  logic [KeyW-1:0] key_mem [POOL_DEPTH];
  logic [NW-1:0]   link_mem [POOL_DEPTH];
  logic [NW-1:0]   fill_q;

  logic [NW-1:0] bhead_q [NUM_BUCKETS];
  logic [CW-1:0] bcnt_q  [NUM_BUCKETS];
  logic [NW-1:0] free_q;

  logic [KeyW-1:0] key_q;
  logic [KeyW:0]   rem_q;
  logic [KeyW-1:0] quo_q;
  logic [1:0]      mstage_q;
  logic [BW-1:0] b_q;
  logic [NW-1:0] walk_q, prev_q;
  logic [CW-1:0] cnt_q, pos_q;
  logic [KeyW-1:0] rkey_q;
  logic [NW-1:0]   rlink_q;
  logic [NW-1:0]   flink_q;

  // A second write port is avoided: the predecessor link is written the
  // cycle after a delete or an insert onto a non-empty chain.
  logic          pend_q;
  logic [NW-1:0] pend_addr_q, pend_val_q;

  logic [KeyW+31:0] prod;
  logic [KeyW:0]    qn;
  logic [NW-1:0] rlink_eff;
  logic [NW-1:0] flink_eff;
  logic [BW-1:0] b_cur;
  logic [CW-1:0] cnt_cur;

  // The reciprocal estimate of the quotient is low by at most one.
  assign prod = {{KeyW{1'b0}}, Recip} * {32'd0, key_q};
  assign qn   = {1'b0, quo_q} * NbExt;

  assign rlink_eff = (walk_q >= fill_q) ? NW'(walk_q + 1'b1) : rlink_q;
  assign flink_eff = (free_q >= fill_q) ? NW'(free_q + 1'b1) : flink_q;

  assign b_cur   = dp_cmd_i.rd_bucket ? rem_q[BW-1:0] : b_q;
  assign cnt_cur = dp_cmd_i.rd_bucket ? bcnt_q[rem_q[BW-1:0]] : cnt_q;

  assign stat_o.mod_done   = (mstage_q == 2'd3);
  assign stat_o.free_empty = (free_q == Nil);
  assign stat_o.head_nil   = (bhead_q[rem_q[BW-1:0]] == Nil);
  assign stat_o.walk_nil   = (walk_q == Nil);
  assign stat_o.key_match  = (rkey_q == key_q);
  assign stat_o.next_nil   = (rlink_eff == Nil);
  assign stat_o.walk_limit = (pos_q > CW'(POOL_DEPTH));

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.rd_node && walk_q != Nil) begin
      rkey_q  <= key_mem[walk_q[IW-1:0]];
      rlink_q <= link_mem[walk_q[IW-1:0]];
    end
    if (dp_cmd_i.rd_bucket && free_q != Nil) begin
      flink_q <= link_mem[free_q[IW-1:0]];
    end
    if (dp_cmd_i.do_insert) begin
      key_mem[free_q[IW-1:0]]  <= key_q;
      link_mem[free_q[IW-1:0]] <= Nil;
    end else if (dp_cmd_i.do_delete) begin
      link_mem[walk_q[IW-1:0]] <= free_q;
    end else if (pend_q) begin
      link_mem[pend_addr_q[IW-1:0]] <= pend_val_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      free_q <= '0;
      pend_q <= 1'b0;
      for (int i = 0; i < NUM_BUCKETS; i++) begin
        bhead_q[i] <= Nil;
        bcnt_q[i]  <= '0;
      end
    end else begin
      pend_q <= 1'b0;
      if (dp_cmd_i.do_insert) begin
        if (free_q >= fill_q) fill_q <= NW'(free_q + 1'b1);
        free_q <= flink_eff;
        bcnt_q[b_q] <= CW'(cnt_q + 1'b1);
        if (walk_q == Nil) begin
          bhead_q[b_q] <= free_q;
        end else begin
          pend_q      <= 1'b1;
          pend_addr_q <= walk_q;
          pend_val_q  <= free_q;
        end
      end else if (dp_cmd_i.do_delete) begin
        if (walk_q >= fill_q) fill_q <= NW'(walk_q + 1'b1);
        free_q <= walk_q;
        if (cnt_q != '0) bcnt_q[b_q] <= CW'(cnt_q - 1'b1);
        if (prev_q == Nil) begin
          bhead_q[b_q] <= rlink_eff;
        end else begin
          pend_q      <= 1'b1;
          pend_addr_q <= prev_q;
          pend_val_q  <= rlink_eff;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (dp_cmd_i.load) begin
      key_q    <= key_i;
      rem_q    <= {1'b0, key_i};
      mstage_q <= '0;
    end else if (dp_cmd_i.mod_step) begin
      unique case (mstage_q)
        2'd0: quo_q <= prod[KeyW+31:32];
        2'd1: rem_q <= {1'b0, key_q} - qn;
        default: if (rem_q >= NbExt) rem_q <= rem_q - NbExt;
      endcase
      if (mstage_q != 2'd3) mstage_q <= mstage_q + 1'b1;
    end
    if (dp_cmd_i.rd_bucket) begin
      b_q        <= rem_q[BW-1:0];
      walk_q     <= bhead_q[rem_q[BW-1:0]];
      cnt_q      <= bcnt_q[rem_q[BW-1:0]];
      prev_q     <= Nil;
      pos_q      <= (bhead_q[rem_q[BW-1:0]] == Nil) ? '0 : CW'(1);
    end else if (dp_cmd_i.advance) begin
      prev_q <= walk_q;
      walk_q <= rlink_eff;
      pos_q  <= CW'(pos_q + 1'b1);
    end
    if (dp_cmd_i.finish) begin
      status_o       <= dp_cmd_i.status;
      bucket_o       <= 4'(b_cur);
      if (dp_cmd_i.status == StatDone) begin
        position_o <= 9'(dp_cmd_i.do_insert ? CW'(cnt_q + 1'b1) : pos_q);
      end else begin
        position_o <= '0;
      end
      if (dp_cmd_i.do_insert)      chain_length_o <= 9'(CW'(cnt_q + 1'b1));
      else if (dp_cmd_i.do_delete) chain_length_o <= 9'(CW'(cnt_q - 1'b1));
      else                         chain_length_o <= 9'(cnt_cur);
    end
  end
endmodule

// ----- hw/rtl/chained_hash_table.sv -----
// Separate-chaining hash table over a bounded node pool with a free list.
// Steps: reciprocal key reduction and bucket lookup (all a full pool or unused command needs),
// then a read and a check per chain node visited, one check for an insert into an empty chain
// and one more read and check on a miss; one operation at a time, next beat taken as result leaves.
// Reset is asynchronous, active low; chains empty and all nodes free at once.
// Depends on cht_pkg, cht_ctrl and cht_dp.
module chained_hash_table #(
  parameter int unsigned NUM_BUCKETS = 10,
  parameter int unsigned POOL_DEPTH  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [30:0] key_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [3:0]  bucket_o,
  output logic [8:0]  position_o,
  output logic [8:0]  chain_length_o
);
  import cht_pkg::*;

  cht_cmd_t  dp_cmd;
  cht_stat_t stat;

  cht_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .cmd_i,
    .out_valid_o, .out_ready_i, .stat_i(stat), .dp_cmd_o(dp_cmd)
  );

  cht_dp #(.NUM_BUCKETS(NUM_BUCKETS), .POOL_DEPTH(POOL_DEPTH)) u_dp (
    .clk_i, .rst_ni, .key_i, .dp_cmd_i(dp_cmd), .stat_o(stat),
    .status_o, .bucket_o, .position_o, .chain_length_o
  );
endmodule

// ----- hw/rtl/cht_checker.sv -----
// Port-level checker for the chained hash table, bound to the top level.
// Depends on chained_hash_table_assert.svh and cht_pkg.
`include "chained_hash_table_assert.svh"
module cht_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic [1:0] status_o,
  input logic [8:0] position_o
);
  import cht_pkg::*;

  `CHT_ASSERT_IMPL(a_status_legal, clk_i, rst_ni, out_valid_o, status_o != 2'd3)
  `CHT_ASSERT_IMPL(a_pos_zero, clk_i, rst_ni, out_valid_o && status_o != StatDone, position_o == 9'd0)
  `CHT_ASSERT_NEXT(a_out_holds, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o))
  `CHT_ASSERT_NEXT(a_no_early_out, clk_i, rst_ni, in_valid_i && in_ready_o, !out_valid_o)
endmodule

bind chained_hash_table cht_checker u_cht_checker (.*);
